// File: hdl/ardtf_pkg.sv
package ardtf_pkg;

  // input beat layout
  localparam int ADDR_W      = 48;
  localparam int BYTE_W      = 8;
  localparam int UUID_W      = 16;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;
  localparam int DEV_W       = 3;

  // action codes carried on tuser
  localparam logic ACT_ADDR = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // configuration register indexes
  localparam logic REG_TARGET  = 1'b0;
  localparam logic REG_CONNECT = 1'b1;

  // register reset values
  localparam logic [UUID_W-1:0] TARGET_RESET  = 16'h0000;
  localparam logic [UUID_W-1:0] CONNECT_RESET = 16'h180D;

  // advertising data structure types holding 16-bit uuid lists
  localparam logic [BYTE_W-1:0] AD_UUID16_PART = 8'h02;
  localparam logic [BYTE_W-1:0] AD_UUID16_FULL = 8'h03;
  localparam logic [BYTE_W-1:0] UUID_STEP      = 8'd2;

  // device flag codes
  localparam logic [1:0] FLAG_NONE = 2'b00;
  localparam logic [1:0] FLAG_NEW  = 2'b01;
  localparam logic [1:0] FLAG_FULL = 2'b10;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch address, clear parse state, restart table scan
    logic scan;    // step the table scan
    logic parse;   // parse the data byte on the input
    logic finish;  // load the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // lookup resolved this cycle
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// File: hdl/adv_report_device_table_uuid_filter.sv
// channel | direction | beat contents
// in_     | slave     | tdata: peer_address, address_type, data_byte; tuser: action; tlast
// out_    | master    | tdata: device_index .. selected_device (one beat per report)
// cfg_    | write     | cfg_index selects target_uuid (0) or connect_uuid (1)
//
// a data byte is parsed as it is accepted; an address item scans the table,
// one table read per cycle from the single-port-read table ram, until a hit or a miss decision
// a beat with tlast is followed by a finish step that loads the output register
// reset is synchronous, active low; table contents are not cleared, entry count is cleared
// a full output register stalls only the finish state, entered after a beat with tlast
module adv_report_device_table_uuid_filter #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [47:0] peer_address, [48] address_type, [56:49] data_byte, [63:57] zero
  input  logic [ardtf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] action
  input  logic                                  in_tuser,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [2:0] device_index, [3] new_device, [4] table_full, [5] service_match,
  // [6] connect_request, [9:7] selected_device, [15:10] zero
  output logic [ardtf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [ardtf_pkg::UUID_W-1:0]          cfg_data
);

  ardtf_pkg::cmd_t cmd;
  ardtf_pkg::sts_t sts;

  ardtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ardtf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_peer_address (in_tdata[47:0]),
    .in_address_type (in_tdata[48]),
    .in_data_byte    (in_tdata[56:49]),
    .in_last         (in_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

// File: hdl/ardtf_ram.sv
module ardtf_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/ardtf_ctrl.sv
module ardtf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_action,
  input  logic            in_last,
  output logic            in_tready,
  input  ardtf_pkg::sts_t sts,
  output ardtf_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_action == ardtf_pkg::ACT_ADDR) begin
            cmd.start = 1'b1;
            last_nxt  = in_last;
            state_nxt = ST_SCAN;
          end else begin
            cmd.parse = 1'b1;
            if (in_last) begin
              state_nxt = ST_FIN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = last_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// File: hdl/ardtf_dp.sv
module ardtf_dp #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ardtf_pkg::cmd_t                       cmd,
  output ardtf_pkg::sts_t                       sts,
  input  logic [ardtf_pkg::ADDR_W-1:0]          in_peer_address,
  input  logic                                  in_address_type,
  input  logic [ardtf_pkg::BYTE_W-1:0]          in_data_byte,
  input  logic                                  in_last,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [ardtf_pkg::UUID_W-1:0]          cfg_data,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ardtf_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ardtf_pkg::ADDR_W + 1;
  localparam int BW = ardtf_pkg::BYTE_W;
  localparam int DW = ardtf_pkg::DEV_W;

  // configuration
  logic [ardtf_pkg::UUID_W-1:0] target_r, target_nxt;
  logic [ardtf_pkg::UUID_W-1:0] connect_r, connect_nxt;

  // lookup
  logic [ardtf_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                         type_r, type_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [CW-1:0]                scan_idx_r, scan_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]                rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]                cur_dev_r, cur_dev_nxt;
  logic [1:0]                   flags_r, flags_nxt;
  logic [DW-1:0]                chosen_r, chosen_nxt;

  // parse state
  logic [BW-1:0] bpos_r, bpos_nxt;
  logic [BW-1:0] sstart_r, sstart_nxt;
  logic [BW-1:0] tpos_r, tpos_nxt;
  logic [BW-1:0] uoff_r, uoff_nxt;
  logic [BW-1:0] stype_r, stype_nxt;
  logic [BW:0]   ulow_r, ulow_nxt;
  logic          match_r, match_nxt;

  // output register
  logic                                 out_valid_r, out_valid_nxt;
  logic [ardtf_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;

  // table memory
  logic          ram_wr_en;
  logic          ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;

  logic                         hit;
  logic                         more;
  logic                         room;
  logic [ardtf_pkg::UUID_W-1:0] uuid;
  logic [BW:0]                  uuid_pos;
  logic [DW-1:0]                sel_dev;
  logic                         conn;

  ardtf_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[IW-1:0]),
    .wr_data ({type_r, addr_r}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign hit  = rd_vld_r && (ram_rd_data[ardtf_pkg::ADDR_W-1:0] == addr_r);
  assign more = scan_idx_r < count_r;
  assign room = count_r < CW'(TABLE_DEPTH);
  assign ram_rd_addr = scan_idx_r[IW-1:0];

  assign sts.scan_done = hit || (!more && !rd_vld_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    target_nxt    = target_r;
    connect_nxt   = connect_r;
    addr_nxt      = addr_r;
    type_nxt      = type_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    cur_dev_nxt   = cur_dev_r;
    flags_nxt     = flags_r;
    chosen_nxt    = chosen_r;
    bpos_nxt      = bpos_r;
    sstart_nxt    = sstart_r;
    tpos_nxt      = tpos_r;
    uoff_nxt      = uoff_r;
    stype_nxt     = stype_r;
    ulow_nxt      = ulow_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    uuid          = {in_data_byte, ulow_r[BW-1:0]};
    uuid_pos      = '0;
    sel_dev       = chosen_r;
    conn          = 1'b0;

    // new report: latch address, drop any report in progress
    if (cmd.start) begin
      addr_nxt     = in_peer_address;
      type_nxt     = in_address_type;
      scan_idx_nxt = '0;
      rd_vld_nxt   = 1'b0;
      bpos_nxt     = '0;
      sstart_nxt   = '0;
      tpos_nxt     = '0;
      uoff_nxt     = '0;
      stype_nxt    = '0;
      ulow_nxt     = '0;
      match_nxt    = 1'b0;
    end

    // table scan, one read per cycle, append on a miss while there is room, else flag full
    if (cmd.scan) begin
      if (hit) begin
        cur_dev_nxt = rd_idx_r;
        flags_nxt   = ardtf_pkg::FLAG_NONE;
      end else if (!rd_vld_r && !more) begin
        if (room) begin
          ram_wr_en   = 1'b1;
          cur_dev_nxt = count_r[IW-1:0];
          flags_nxt   = ardtf_pkg::FLAG_NEW;
          count_nxt   = count_r + CW'(1);
        end else begin
          cur_dev_nxt = '0;
          flags_nxt   = ardtf_pkg::FLAG_FULL;
        end
      end else begin
        rd_vld_nxt = more;
        if (more) begin
          ram_rd_en    = 1'b1;
          rd_idx_nxt   = scan_idx_r[IW-1:0];
          scan_idx_nxt = scan_idx_r + CW'(1);
        end
      end
    end

    // data byte: structure walk and uuid compare
    if (cmd.parse) begin
      if (ulow_r[BW]) begin
        if (uuid == target_r) begin
          match_nxt = 1'b1;
        end else begin
          uoff_nxt = uoff_r + ardtf_pkg::UUID_STEP;
        end
        ulow_nxt = '0;
      end
      if (bpos_r == tpos_r) begin
        stype_nxt = in_data_byte;
      end
      // type position plus offset does not wrap
      uuid_pos = {1'b0, tpos_r} + {1'b0, uoff_nxt};
      if (bpos_r == sstart_r) begin
        tpos_nxt   = bpos_r + BW'(1);
        sstart_nxt = sstart_r + in_data_byte + BW'(1);
        uoff_nxt   = BW'(1);
      end else if ({1'b0, bpos_r} == uuid_pos) begin
        if ((stype_nxt == ardtf_pkg::AD_UUID16_PART ||
             stype_nxt == ardtf_pkg::AD_UUID16_FULL) && !in_last) begin
          ulow_nxt = {1'b1, in_data_byte};
        end
      end
      bpos_nxt = bpos_r + BW'(1);
    end

    // end of report: load result, clear parse state; otherwise out_tready empties the output
    if (cmd.finish) begin
      if (match_r) begin
        sel_dev = DW'(cur_dev_r);
        conn    = (target_r == connect_r);
      end
      chosen_nxt    = sel_dev;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {6'b0, sel_dev, conn, match_r, flags_r[1], flags_r[0],
                       DW'(cur_dev_r)};
      bpos_nxt      = '0;
      sstart_nxt    = '0;
      tpos_nxt      = '0;
      uoff_nxt      = '0;
      stype_nxt     = '0;
      ulow_nxt      = '0;
      match_nxt     = 1'b0;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        ardtf_pkg::REG_TARGET:  target_nxt  = cfg_data;
        ardtf_pkg::REG_CONNECT: connect_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // control and parse registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= ardtf_pkg::TARGET_RESET;
      connect_r   <= ardtf_pkg::CONNECT_RESET;
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      cur_dev_r   <= '0;
      flags_r     <= ardtf_pkg::FLAG_NONE;
      chosen_r    <= '0;
      bpos_r      <= '0;
      sstart_r    <= '0;
      tpos_r      <= '0;
      uoff_r      <= '0;
      stype_r     <= '0;
      ulow_r      <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      target_r    <= target_nxt;
      connect_r   <= connect_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cur_dev_r   <= cur_dev_nxt;
      flags_r     <= flags_nxt;
      chosen_r    <= chosen_nxt;
      bpos_r      <= bpos_nxt;
      sstart_r    <= sstart_nxt;
      tpos_r      <= tpos_nxt;
      uoff_r      <= uoff_nxt;
      stype_r     <= stype_nxt;
      ulow_r      <= ulow_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    type_r     <= type_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
